FILE: hdl/vad_sentence_segmenter_core_macros.svh
// Assertion helpers shared by the segmenter RTL.
// Every use expects signals named clk and rst_n in the enclosing module.
`ifndef VAD_SENTENCE_SEGMENTER_CORE_MACROS_SVH
`define VAD_SENTENCE_SEGMENTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segmenter assertion failed");

// Next-cycle implication, checked outside reset.
`define VSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segmenter assertion failed");

`endif

FILE: hdl/vss_pkg.sv
package vss_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SPEAKER_W  = 8;
  localparam int ACTION_W   = 2;
  localparam int SUM_W      = 26;
  localparam int FS_W       = 10;
  localparam int MPF_W      = 10;
  localparam int THR_W      = 15;
  localparam int LIM_W      = 16;
  localparam int CNT_W      = 24;
  localparam int ID_W       = 32;
  localparam int DUR_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUNCT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRM_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MS_PER_FRM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT = 3'd5;

  // register reset values
  localparam logic [FS_W-1:0]  RST_FRM_LEN     = 10'd160;
  localparam logic [MPF_W-1:0] RST_MS_PER_FRM  = 10'd10;
  localparam logic [THR_W-1:0] RST_THRESHOLD   = 15'd300;
  localparam logic [LIM_W-1:0] RST_SILENCE_LIM = 16'd40;
  localparam logic [LIM_W-1:0] RST_MIN_SPEECH  = 16'd20;
  localparam logic [LIM_W-1:0] RST_MAX_SEGMENT = 16'd1500;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  typedef struct packed {
    logic [FS_W-1:0]  fs_eff;
    logic [SUM_W-1:0] thr_prod;
    logic [LIM_W-1:0] silence_limit;
    logic [LIM_W-1:0] min_speech;
    logic [LIM_W-1:0] max_segment;
  } seg_cfg_t;

  typedef struct packed {
    logic                 frame_end;
    logic                 frame_speech;
    logic                 accumulating;
    logic                 locked;
    logic [ID_W-1:0]      locked_id;
    logic [CNT_W-1:0]     locked_frames;
    logic [SPEAKER_W-1:0] locked_speaker;
  } seg_res_t;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/vss_in_if.sv
interface vss_in_if;
  logic                               valid;
  logic                               ready;
  logic [vss_pkg::ACTION_W-1:0]       action;
  logic signed [vss_pkg::SAMPLE_W-1:0] sample;
  logic [vss_pkg::SPEAKER_W-1:0]      speaker;

  modport source (output valid, action, sample, speaker, input ready);
  modport sink   (input valid, action, sample, speaker, output ready);
endinterface

FILE: hdl/vss_out_if.sv
interface vss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_end;
  logic                          frame_speech;
  logic                          accumulating;
  logic                          locked;
  logic [vss_pkg::ID_W-1:0]      locked_id;
  logic [vss_pkg::CNT_W-1:0]     locked_frames;
  logic [vss_pkg::DUR_W-1:0]     duration_ms;
  logic [vss_pkg::SPEAKER_W-1:0] locked_speaker;

  modport source (output valid, frame_end, frame_speech, accumulating, locked, locked_id,
                  locked_frames, duration_ms, locked_speaker, input ready);
  modport sink   (input valid, frame_end, frame_speech, accumulating, locked, locked_id,
                  locked_frames, duration_ms, locked_speaker, output ready);
endinterface

FILE: hdl/vss_cfg_if.sv
interface vss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vss_pkg::CFG_IDX_W-1:0]  index;
  logic [vss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/vss_seg_core.sv
`include "vad_sentence_segmenter_core_macros.svh"

module vss_seg_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_en,
  input  logic [vss_pkg::ACTION_W-1:0]        action,
  input  logic signed [vss_pkg::SAMPLE_W-1:0] sample,
  input  logic [vss_pkg::SPEAKER_W-1:0]       speaker,
  input  vss_pkg::seg_cfg_t                   cfg,
  output vss_pkg::seg_res_t                   res
);

  logic                            mode_r, mode_nxt;
  logic [vss_pkg::SUM_W-1:0]       psum_r, psum_nxt;
  logic [vss_pkg::FS_W-1:0]        nsamp_r, nsamp_nxt;
  logic [vss_pkg::CNT_W-1:0]       silence_r, silence_nxt;
  logic [vss_pkg::CNT_W-1:0]       speech_r, speech_nxt;
  logic [vss_pkg::CNT_W-1:0]       seglen_r, seglen_nxt;
  logic [vss_pkg::ID_W-1:0]        next_id_r, next_id_nxt;
  logic [vss_pkg::SPEAKER_W-1:0]   spk_r, spk_nxt;

  always_comb begin
    logic [vss_pkg::MAG_W-1:0] mag;
    logic [vss_pkg::SUM_W-1:0] sum_new;
    logic [vss_pkg::FS_W-1:0]  cnt_new;
    logic                      speech;
    logic                      lock;

    mode_nxt    = mode_r;
    psum_nxt    = psum_r;
    nsamp_nxt   = nsamp_r;
    silence_nxt = silence_r;
    speech_nxt  = speech_r;
    seglen_nxt  = seglen_r;
    next_id_nxt = next_id_r;
    spk_nxt     = spk_r;
    res         = '0;
    lock        = 1'b0;

    mag     = sample[vss_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    sum_new = psum_r + vss_pkg::SUM_W'(mag);
    cnt_new = nsamp_r + 1'b1;
    speech  = (sum_new >= cfg.thr_prod);

    unique case (action)
      vss_pkg::ACT_SAMPLE: begin
        spk_nxt = speaker;
        if (cnt_new >= cfg.fs_eff) begin
          psum_nxt         = '0;
          nsamp_nxt        = '0;
          res.frame_end    = 1'b1;
          res.frame_speech = speech;
          if (!mode_r) begin
            // onset frame opens a segment, no lock test
            if (speech) begin
              mode_nxt    = 1'b1;
              silence_nxt = '0;
              speech_nxt  = vss_pkg::CNT_W'(1);
              seglen_nxt  = vss_pkg::CNT_W'(1);
            end
          end else begin
            seglen_nxt = vss_pkg::inc_sat(seglen_r);
            if (speech) begin
              speech_nxt  = vss_pkg::inc_sat(speech_r);
              silence_nxt = '0;
            end else begin
              silence_nxt = vss_pkg::inc_sat(silence_r);
            end
            lock = (speech_nxt >= vss_pkg::CNT_W'(cfg.min_speech)) &&
                   ((seglen_nxt >= vss_pkg::CNT_W'(cfg.max_segment)) ||
                    (silence_nxt >= vss_pkg::CNT_W'(cfg.silence_limit)));
          end
        end else begin
          psum_nxt  = sum_new;
          nsamp_nxt = cnt_new;
        end
      end
      vss_pkg::ACT_PUNCT: begin
        lock = mode_r && (speech_r >= vss_pkg::CNT_W'(cfg.min_speech));
      end
      vss_pkg::ACT_RESET: begin
        mode_nxt    = 1'b0;
        silence_nxt = '0;
        speech_nxt  = '0;
        seglen_nxt  = '0;
        psum_nxt    = '0;
        nsamp_nxt   = '0;
      end
      default: begin
      end
    endcase

    if (lock) begin
      res.locked         = 1'b1;
      res.locked_id      = next_id_r;
      res.locked_frames  = seglen_nxt;
      res.locked_speaker = spk_nxt;
      next_id_nxt        = next_id_r + 1'b1;
      mode_nxt           = 1'b0;
      silence_nxt        = '0;
      speech_nxt         = '0;
      seglen_nxt         = '0;
    end

    res.accumulating = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      psum_r    <= '0;
      nsamp_r   <= '0;
      silence_r <= '0;
      speech_r  <= '0;
      seglen_r  <= '0;
      next_id_r <= '0;
      spk_r     <= '0;
    end else if (item_en) begin
      mode_r    <= mode_nxt;
      psum_r    <= psum_nxt;
      nsamp_r   <= nsamp_nxt;
      silence_r <= silence_nxt;
      speech_r  <= speech_nxt;
      seglen_r  <= seglen_nxt;
      next_id_r <= next_id_nxt;
      spk_r     <= spk_nxt;
    end
  end

  `VSS_ASSERT_IMP(a_idle_counters_clear, !mode_r,
                  seglen_r == '0 && speech_r == '0 && silence_r == '0)
  `VSS_ASSERT_NXT(a_lock_advances_id, item_en && res.locked,
                  next_id_r == $past(next_id_r) + 1'b1 && !mode_r)
  `VSS_ASSERT_NXT(a_id_holds_without_lock, !(item_en && res.locked),
                  next_id_r == $past(next_id_r))
  `VSS_ASSERT_IMP(a_accum_has_speech, mode_r, speech_r != '0 && seglen_r != '0)

endmodule

FILE: hdl/vad_sentence_segmenter_core.sv
// Energy-based sentence segmenter.
// in_ch carries one item per transfer: an audio sample with its speaker id, a
// punctuation notice, or a segmenter reset. out_ch returns exactly one result
// per input item, in order: frame completion and class, the mode after the
// item, and on a lock the segment id, frame count, duration and speaker.
// cfg_ch writes the six registers (index 0 frame length .. 5 max segment length);
// it is always ready. Writes must be made only while no item is in flight;
// the block does not enforce this. Each item passes through the input register,
// then the segment state update into the result register, then the duration
// multiply into the output register. Throughput is one item per cycle while
// the output is not stalled; the segment state update is a combinational add,
// compare and count step against a registered threshold product.
// A stalled receiver freezes the whole pipeline: in_ch.ready follows
// out_ch.ready whenever the output register is full.
// rst_n (synchronous) returns the registers to their defaults, clears the
// segment state and segment id, and empties the pipeline.
`include "vad_sentence_segmenter_core_macros.svh"

module vad_sentence_segmenter_core (
  input  logic     clk,
  input  logic     rst_n,
  vss_in_if.sink   in_ch,
  vss_out_if.source out_ch,
  vss_cfg_if.sink  cfg_ch
);

  logic [vss_pkg::FS_W-1:0]  frm_len_r;
  logic [vss_pkg::MPF_W-1:0] ms_per_frm_r;
  logic [vss_pkg::THR_W-1:0] threshold_r;
  logic [vss_pkg::LIM_W-1:0] silence_lim_r;
  logic [vss_pkg::LIM_W-1:0] min_speech_r;
  logic [vss_pkg::LIM_W-1:0] max_segment_r;
  logic [vss_pkg::SUM_W-1:0] thr_prod_r;
  logic [vss_pkg::FS_W-1:0]  fs_eff;

  logic                                in_v_r;
  logic [vss_pkg::ACTION_W-1:0]        in_action_r;
  logic signed [vss_pkg::SAMPLE_W-1:0] in_sample_r;
  logic [vss_pkg::SPEAKER_W-1:0]       in_speaker_r;

  logic                res_v_r;
  vss_pkg::seg_res_t   res_r;
  vss_pkg::seg_res_t   seg_res;
  vss_pkg::seg_cfg_t   seg_cfg;

  logic                out_v_r;
  vss_pkg::seg_res_t   out_r;
  logic [vss_pkg::DUR_W-1:0] dur_r;

  logic en;
  logic item_en;
  logic [vss_pkg::CNT_W+vss_pkg::MPF_W-1:0] dur_full;
  logic [vss_pkg::DUR_W-1:0]                dur_sat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_len_r     <= vss_pkg::RST_FRM_LEN;
      ms_per_frm_r  <= vss_pkg::RST_MS_PER_FRM;
      threshold_r   <= vss_pkg::RST_THRESHOLD;
      silence_lim_r <= vss_pkg::RST_SILENCE_LIM;
      min_speech_r  <= vss_pkg::RST_MIN_SPEECH;
      max_segment_r <= vss_pkg::RST_MAX_SEGMENT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vss_pkg::REG_FRM_LEN:     frm_len_r     <= cfg_ch.data[vss_pkg::FS_W-1:0];
        vss_pkg::REG_MS_PER_FRM:  ms_per_frm_r  <= cfg_ch.data[vss_pkg::MPF_W-1:0];
        vss_pkg::REG_THRESHOLD:   threshold_r   <= cfg_ch.data[vss_pkg::THR_W-1:0];
        vss_pkg::REG_SILENCE_LIM: silence_lim_r <= cfg_ch.data[vss_pkg::LIM_W-1:0];
        vss_pkg::REG_MIN_SPEECH:  min_speech_r  <= cfg_ch.data[vss_pkg::LIM_W-1:0];
        vss_pkg::REG_MAX_SEGMENT: max_segment_r <= cfg_ch.data[vss_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero frame size acts as one
  assign fs_eff = (frm_len_r == '0) ? vss_pkg::FS_W'(1) : frm_len_r;

  // speech test is sum >= (threshold + 1) * frame size; keep the product registered
  always_ff @(posedge clk) begin
    thr_prod_r <= (vss_pkg::SUM_W'(threshold_r) + vss_pkg::SUM_W'(1)) *
                  vss_pkg::SUM_W'(fs_eff);
  end

  assign seg_cfg.fs_eff        = fs_eff;
  assign seg_cfg.thr_prod      = thr_prod_r;
  assign seg_cfg.silence_limit = silence_lim_r;
  assign seg_cfg.min_speech    = min_speech_r;
  assign seg_cfg.max_segment   = max_segment_r;

  // advance every stage together unless the output is held
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign item_en     = en && in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      in_v_r  <= in_ch.valid;
      res_v_r <= in_v_r;
      out_v_r <= res_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_ch.valid) begin
      in_action_r  <= in_ch.action;
      in_sample_r  <= in_ch.sample;
      in_speaker_r <= in_ch.speaker;
    end
  end

  vss_seg_core u_seg (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (item_en),
    .action  (in_action_r),
    .sample  (in_sample_r),
    .speaker (in_speaker_r),
    .cfg     (seg_cfg),
    .res     (seg_res)
  );

  always_ff @(posedge clk) begin
    if (item_en) begin
      res_r <= seg_res;
    end
  end

  assign dur_full = res_r.locked_frames * ms_per_frm_r;
  assign dur_sat  = (dur_full[vss_pkg::CNT_W+vss_pkg::MPF_W-1:vss_pkg::DUR_W] != '0) ?
                    {vss_pkg::DUR_W{1'b1}} : dur_full[vss_pkg::DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (en && res_v_r) begin
      out_r <= res_r;
      dur_r <= dur_sat;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.frame_end      = out_r.frame_end;
  assign out_ch.frame_speech   = out_r.frame_speech;
  assign out_ch.accumulating   = out_r.accumulating;
  assign out_ch.locked         = out_r.locked;
  assign out_ch.locked_id      = out_r.locked_id;
  assign out_ch.locked_frames  = out_r.locked_frames;
  assign out_ch.duration_ms    = dur_r;
  assign out_ch.locked_speaker = out_r.locked_speaker;

  `VSS_ASSERT_NXT(a_stall_freezes_pipe, out_v_r && !out_ch.ready,
                  $stable(in_v_r) && $stable(res_v_r))
  `VSS_ASSERT_IMP(a_speech_needs_frame, out_v_r && out_r.frame_speech, out_r.frame_end)
  `VSS_ASSERT_IMP(a_lock_leaves_idle, out_v_r && out_r.locked, !out_r.accumulating)

endmodule
